// ===== rtl/prefix_bucketed_sorted_index_lookup_core_defines.svh =====
// assertion macros used by the checker file
`ifndef PREFIX_BUCKETED_SORTED_INDEX_LOOKUP_CORE_DEFINES_SVH
`define PREFIX_BUCKETED_SORTED_INDEX_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PBSIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PBSIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbsil_pkg.sv =====
// shared constants, codes and types of the bucketed sorted lookup core
`timescale 1ns / 1ps

package pbsil_pkg;

    localparam int TABLE_DEPTH   = 65536;
    localparam int PREFIX_MAX    = 12;

    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int BUCKET_W      = PREFIX_MAX;
    localparam int BUCKET_COUNT  = 1 << PREFIX_MAX;
    localparam int NUB_W         = BUCKET_W + 1;

    localparam int KEY_W         = 64;
    localparam int CMD_W         = 2;
    localparam int ENTRY_INDEX_W = 16;
    localparam int STATUS_W      = 2;

    localparam int KEY_BITS_W    = 7;
    localparam int BUCKET_BITS_W = 4;
    localparam int CFG_DATA_W    = 7;
    localparam int REG_IDX_W     = 1;

    localparam logic [REG_IDX_W-1:0] REG_KEY_BITS    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BUCKET_BITS = 1'b1;

    localparam logic [KEY_BITS_W-1:0]    KEY_BITS_RST    = 7'd64;
    localparam logic [BUCKET_BITS_W-1:0] BUCKET_BITS_RST = 4'd12;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_WIDE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_BITS_W-1:0]    key_bits;
        logic [BUCKET_BITS_W-1:0] bucket_bits;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } key_mem_req_t;

    typedef struct packed {
        logic                we;
        logic [BUCKET_W-1:0] waddr;
        logic [CNT_W-1:0]    wdata;
        logic [BUCKET_W-1:0] raddr;
    } bkt_mem_req_t;

endpackage

// ===== rtl/pbsil_in_if.sv =====
// request channel: command and key
`timescale 1ns / 1ps

interface pbsil_in_if;
    logic                         valid;
    logic                         ready;
    logic [pbsil_pkg::CMD_W-1:0]  command;
    logic [pbsil_pkg::KEY_W-1:0]  key_value;

    modport source (output valid, command, key_value, input ready);
    modport sink (input valid, command, key_value, output ready);
endinterface

// ===== rtl/pbsil_out_if.sv =====
// response channel: found flag, entry index and status
`timescale 1ns / 1ps

interface pbsil_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [pbsil_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic [pbsil_pkg::STATUS_W-1:0]      status;

    modport source (output valid, found, entry_index, status, input ready);
    modport sink (input valid, found, entry_index, status, output ready);
endinterface

// ===== rtl/pbsil_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
`timescale 1ns / 1ps

module pbsil_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pbsil_ctrl.sv =====
// sequencer: clear, append with bucket fill, windowed binary search, result register
`timescale 1ns / 1ps

module pbsil_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    pbsil_in_if.sink                            req,
    pbsil_out_if.source                         rsp,
    input  pbsil_pkg::cfg_t                     cfg,
    output pbsil_pkg::key_mem_req_t             key_req,
    input  logic [pbsil_pkg::KEY_W-1:0]         key_rdata,
    output pbsil_pkg::bkt_mem_req_t             bkt_req,
    input  logic [pbsil_pkg::CNT_W-1:0]         bkt_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_APPEND,
        S_BWAIT,
        S_SEARCH,
        S_FINAL,
        S_DONE
    } state_t;

    state_t                                state_reg, state_next;
    pbsil_pkg::cmd_t                       cmd_reg, cmd_next;
    logic [pbsil_pkg::KEY_W-1:0]           key_reg, key_next;
    logic [pbsil_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [pbsil_pkg::NUB_W-1:0]           nub_reg, nub_next;
    logic [pbsil_pkg::CNT_W-1:0]           cur_run_reg, cur_run_next;
    logic [pbsil_pkg::CNT_W-1:0]           long_run_reg, long_run_next;
    logic [pbsil_pkg::KEY_W-1:0]           prev_key_reg, prev_key_next;
    logic [pbsil_pkg::BUCKET_W-1:0]        bucket_reg, bucket_next;
    logic                                  use_bkt_reg, use_bkt_next;
    logic                                  new_run_reg, new_run_next;
    logic [pbsil_pkg::CNT_W-1:0]           first_reg, first_next;
    logic [pbsil_pkg::CNT_W-1:0]           n_reg, n_next;
    logic [pbsil_pkg::CNT_W-1:0]           mid_reg, mid_next;
    logic [pbsil_pkg::CNT_W-1:0]           end_reg, end_next;
    logic                                  res_found_reg, res_found_next;
    logic [pbsil_pkg::ENTRY_INDEX_W-1:0]   res_index_reg, res_index_next;
    pbsil_pkg::status_t                    res_status_reg, res_status_next;
    logic                                  out_valid_reg, out_valid_next;
    logic                                  out_found_reg, out_found_next;
    logic [pbsil_pkg::ENTRY_INDEX_W-1:0]   out_index_reg, out_index_next;
    pbsil_pkg::status_t                    out_status_reg, out_status_next;

    logic [pbsil_pkg::KEY_BITS_W-1:0]      k_eff;
    logic [pbsil_pkg::KEY_BITS_W-1:0]      p_eff;
    logic [pbsil_pkg::KEY_BITS_W-1:0]      shift_amt;
    logic [pbsil_pkg::KEY_W-1:0]           key_shifted;
    logic [pbsil_pkg::BUCKET_W-1:0]        bucket_v;
    logic                                  wide_v;
    logic [pbsil_pkg::CNT_W-1:0]           start_v;
    logic [pbsil_pkg::CNT_W-1:0]           lim_v;
    logic [pbsil_pkg::CNT_W-1:0]           run_v;
    logic [pbsil_pkg::CNT_W-1:0]           half_v;
    logic [pbsil_pkg::CNT_W-1:0]           first_v;
    logic [pbsil_pkg::CNT_W-1:0]           n_v;
    logic [pbsil_pkg::CNT_W-1:0]           mid_v;

    // effective widths and bucket of the held key
    always_comb
    begin
        if (cfg.key_bits == '0)
        begin
            k_eff = pbsil_pkg::KEY_BITS_W'(1);
        end
        else if (cfg.key_bits > pbsil_pkg::KEY_BITS_W'(pbsil_pkg::KEY_W))
        begin
            k_eff = pbsil_pkg::KEY_BITS_W'(pbsil_pkg::KEY_W);
        end
        else
        begin
            k_eff = cfg.key_bits;
        end

        p_eff = pbsil_pkg::KEY_BITS_W'(cfg.bucket_bits);
        if (p_eff == '0)
        begin
            p_eff = pbsil_pkg::KEY_BITS_W'(1);
        end
        if (p_eff > pbsil_pkg::KEY_BITS_W'(pbsil_pkg::PREFIX_MAX))
        begin
            p_eff = pbsil_pkg::KEY_BITS_W'(pbsil_pkg::PREFIX_MAX);
        end
        if (p_eff > k_eff)
        begin
            p_eff = k_eff;
        end

        shift_amt   = k_eff - p_eff;
        key_shifted = key_reg >> shift_amt;
        bucket_v    = pbsil_pkg::BUCKET_W'(key_shifted)
                    & ~({pbsil_pkg::BUCKET_W{1'b1}} << p_eff);
        wide_v      = (k_eff < pbsil_pkg::KEY_BITS_W'(pbsil_pkg::KEY_W))
                    && ((key_reg >> k_eff) != '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        nub_next        = nub_reg;
        cur_run_next    = cur_run_reg;
        long_run_next   = long_run_reg;
        prev_key_next   = prev_key_reg;
        bucket_next     = bucket_reg;
        use_bkt_next    = use_bkt_reg;
        new_run_next    = new_run_reg;
        first_next      = first_reg;
        n_next          = n_reg;
        mid_next        = mid_reg;
        end_next        = end_reg;
        res_found_next  = res_found_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;

        start_v = '0;
        lim_v   = '0;
        run_v   = '0;
        half_v  = '0;
        first_v = '0;
        n_v     = '0;
        mid_v   = '0;

        key_req.we    = 1'b0;
        key_req.waddr = count_reg[pbsil_pkg::ADDR_W-1:0];
        key_req.wdata = key_reg;
        key_req.raddr = mid_reg[pbsil_pkg::ADDR_W-1:0];
        bkt_req.we    = 1'b0;
        bkt_req.waddr = nub_reg[pbsil_pkg::BUCKET_W-1:0];
        bkt_req.wdata = count_reg;
        bkt_req.raddr = bucket_v;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = pbsil_pkg::cmd_t'(req.command);
                    key_next   = req.key_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_found_next  = 1'b0;
                res_index_next  = '0;
                res_status_next = pbsil_pkg::ST_OK;
                state_next      = S_DONE;
                case (cmd_reg)
                    pbsil_pkg::CMD_CLEAR:
                    begin
                        count_next    = '0;
                        nub_next      = '0;
                        cur_run_next  = '0;
                        long_run_next = '0;
                        prev_key_next = '0;
                    end

                    pbsil_pkg::CMD_APPEND:
                    begin
                        res_index_next = pbsil_pkg::ENTRY_INDEX_W'(count_reg);
                        if (wide_v)
                        begin
                            res_status_next = pbsil_pkg::ST_WIDE;
                        end
                        else if ((count_reg != '0) && (key_reg < prev_key_reg))
                        begin
                            res_status_next = pbsil_pkg::ST_ORDER;
                        end
                        else if (count_reg >= pbsil_pkg::CNT_W'(pbsil_pkg::TABLE_DEPTH))
                        begin
                            res_status_next = pbsil_pkg::ST_FULL;
                        end
                        else
                        begin
                            bucket_next = bucket_v;
                            if ({1'b0, bucket_v} >= nub_reg)
                            begin
                                new_run_next = 1'b1;
                                state_next   = S_FILL;
                            end
                            else
                            begin
                                new_run_next = 1'b0;
                                state_next   = S_APPEND;
                            end
                        end
                    end

                    pbsil_pkg::CMD_LOOKUP:
                    begin
                        if (wide_v)
                        begin
                            res_status_next = pbsil_pkg::ST_WIDE;
                        end
                        else
                        begin
                            use_bkt_next = ({1'b0, bucket_v} < nub_reg);
                            state_next   = S_BWAIT;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // one bucket start written per cycle up to the key's bucket
            S_FILL:
            begin
                bkt_req.we = 1'b1;
                nub_next   = nub_reg + 1'b1;
                if (nub_reg == {1'b0, bucket_reg})
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                key_req.we    = 1'b1;
                count_next    = count_reg + 1'b1;
                prev_key_next = key_reg;
                run_v         = new_run_reg ? pbsil_pkg::CNT_W'(1) : cur_run_reg + 1'b1;
                cur_run_next  = run_v;
                if (run_v > long_run_reg)
                begin
                    long_run_next = run_v;
                end
                state_next = S_DONE;
            end

            // bucket start is back: clamp and issue the first probe unless the window is empty
            S_BWAIT:
            begin
                start_v = use_bkt_reg ? bkt_rdata : count_reg;
                lim_v   = count_reg - long_run_reg;
                if (start_v > lim_v)
                begin
                    start_v = lim_v;
                end
                first_next = start_v;
                end_next   = start_v + long_run_reg;
                n_next     = long_run_reg;
                if (long_run_reg != '0)
                begin
                    mid_v         = start_v + (long_run_reg >> 1);
                    mid_next      = mid_v;
                    key_req.raddr = mid_v[pbsil_pkg::ADDR_W-1:0];
                    state_next    = S_SEARCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // probe data is back: narrow the window and issue the next probe
            S_SEARCH:
            begin
                half_v = n_reg >> 1;
                if (key_rdata < key_reg)
                begin
                    first_v = mid_reg + 1'b1;
                    n_v     = n_reg - half_v - 1'b1;
                end
                else
                begin
                    first_v = first_reg;
                    n_v     = half_v;
                end
                first_next = first_v;
                n_next     = n_v;
                if (n_v != '0)
                begin
                    mid_v         = first_v + (n_v >> 1);
                    mid_next      = mid_v;
                    key_req.raddr = mid_v[pbsil_pkg::ADDR_W-1:0];
                end
                else if (first_v < end_reg)
                begin
                    key_req.raddr = first_v[pbsil_pkg::ADDR_W-1:0];
                    state_next    = S_FINAL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FINAL:
            begin
                if (key_rdata == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_index_next = pbsil_pkg::ENTRY_INDEX_W'(first_reg);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_index_next  = res_index_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= pbsil_pkg::CMD_NOP;
            key_reg        <= '0;
            count_reg      <= '0;
            nub_reg        <= '0;
            cur_run_reg    <= '0;
            long_run_reg   <= '0;
            prev_key_reg   <= '0;
            bucket_reg     <= '0;
            use_bkt_reg    <= 1'b0;
            new_run_reg    <= 1'b0;
            first_reg      <= '0;
            n_reg          <= '0;
            mid_reg        <= '0;
            end_reg        <= '0;
            res_found_reg  <= 1'b0;
            res_index_reg  <= '0;
            res_status_reg <= pbsil_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_status_reg <= pbsil_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            count_reg      <= count_next;
            nub_reg        <= nub_next;
            cur_run_reg    <= cur_run_next;
            long_run_reg   <= long_run_next;
            prev_key_reg   <= prev_key_next;
            bucket_reg     <= bucket_next;
            use_bkt_reg    <= use_bkt_next;
            new_run_reg    <= new_run_next;
            first_reg      <= first_next;
            n_reg          <= n_next;
            mid_reg        <= mid_next;
            end_reg        <= end_next;
            res_found_reg  <= res_found_next;
            res_index_reg  <= res_index_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_index_reg  <= out_index_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.status      = out_status_reg;

endmodule

// ===== rtl/prefix_bucketed_sorted_index_lookup_core.sv =====
// top level: configuration registers, key and bucket memories, sequencer
//
// channel  | dir | handshake     | payload
// req      | in  | valid / ready | command, key_value
// rsp      | out | valid / ready | found, entry_index, status
// cfg      | in  | cfg_we only   | cfg_index, cfg_data
//
// one item at a time; a new item is taken while the previous result waits in rsp
// clear, no-op, rejected append and wide lookup: decode, then result state
// append: decode, bucket start fill where needed, key write, result state
// lookup: decode, bucket start read, one search step per halving of the longest-run window,
// final compare if needed, result state; the single key memory read port gives one probe per cycle
// reset clears control state only; both memories need no clearing pass
// a stalled rsp holds the sequencer in its result state, no item is lost
`timescale 1ns / 1ps

module prefix_bucketed_sorted_index_lookup_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    pbsil_in_if.sink                              req,
    pbsil_out_if.source                           rsp,
    input  logic                                  cfg_we,
    input  logic [pbsil_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [pbsil_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [pbsil_pkg::KEY_BITS_W-1:0]    key_bits_reg, key_bits_next;
    logic [pbsil_pkg::BUCKET_BITS_W-1:0] bucket_bits_reg, bucket_bits_next;
    pbsil_pkg::cfg_t                     cfg;
    pbsil_pkg::key_mem_req_t             key_req;
    pbsil_pkg::bkt_mem_req_t             bkt_req;
    logic [pbsil_pkg::KEY_W-1:0]         key_rdata;
    logic [pbsil_pkg::CNT_W-1:0]         bkt_rdata;

    always_comb
    begin
        key_bits_next    = key_bits_reg;
        bucket_bits_next = bucket_bits_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pbsil_pkg::REG_KEY_BITS:
                begin
                    key_bits_next = cfg_data[pbsil_pkg::KEY_BITS_W-1:0];
                end
                pbsil_pkg::REG_BUCKET_BITS:
                begin
                    bucket_bits_next = cfg_data[pbsil_pkg::BUCKET_BITS_W-1:0];
                end
                default:
                begin
                    key_bits_next = key_bits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bits_reg    <= pbsil_pkg::KEY_BITS_RST;
            bucket_bits_reg <= pbsil_pkg::BUCKET_BITS_RST;
        end
        else
        begin
            key_bits_reg    <= key_bits_next;
            bucket_bits_reg <= bucket_bits_next;
        end
    end

    assign cfg.key_bits    = key_bits_reg;
    assign cfg.bucket_bits = bucket_bits_reg;

    pbsil_ram #(
        .DEPTH (pbsil_pkg::TABLE_DEPTH),
        .WIDTH (pbsil_pkg::KEY_W)
    ) u_key_mem (
        .clk   (clk),
        .we    (key_req.we),
        .waddr (key_req.waddr),
        .wdata (key_req.wdata),
        .raddr (key_req.raddr),
        .rdata (key_rdata)
    );

    pbsil_ram #(
        .DEPTH (pbsil_pkg::BUCKET_COUNT),
        .WIDTH (pbsil_pkg::CNT_W)
    ) u_bkt_mem (
        .clk   (clk),
        .we    (bkt_req.we),
        .waddr (bkt_req.waddr),
        .wdata (bkt_req.wdata),
        .raddr (bkt_req.raddr),
        .rdata (bkt_rdata)
    );

    pbsil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .key_req   (key_req),
        .key_rdata (key_rdata),
        .bkt_req   (bkt_req),
        .bkt_rdata (bkt_rdata)
    );

endmodule

// ===== rtl/pbsil_checker.sv =====
// port-level checker for the lookup core, bound to the top level
`timescale 1ns / 1ps
`include "prefix_bucketed_sorted_index_lookup_core_defines.svh"

module pbsil_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic                                rsp_found,
    input logic [pbsil_pkg::ENTRY_INDEX_W-1:0] rsp_entry_index,
    input logic [pbsil_pkg::STATUS_W-1:0]      rsp_status
);

    // a stalled result stays offered
    `PBSIL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

    // a stalled result keeps its payload
    `PBSIL_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_found) && $stable(rsp_entry_index) && $stable(rsp_status), "rsp payload changed while stalled")

    // one item in work at a time
    `PBSIL_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "req taken while an item is in work")

    // a hit always reports ok
    `PBSIL_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found, rsp_status == pbsil_pkg::ST_OK, "found with error status")

endmodule

bind prefix_bucketed_sorted_index_lookup_core pbsil_checker u_pbsil_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_entry_index (rsp.entry_index),
    .rsp_status      (rsp.status)
);
